// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the ranker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TKR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TKR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TKR_ASSERT(lbl, prop, msg)
`define TKR_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/tkr_pkg.sv -----
`default_nettype none
package tkr_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [5:0] LIMIT_RESET = 6'd20;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] user_time;
    logic [31:0] system_time;
    logic [31:0] real_time;
    logic [15:0] function_id;
    logic [15:0] file_id;
    logic [19:0] line_number;
    logic [31:0] call_count;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  rank;
    logic [15:0] out_function;
    logic [15:0] out_file;
    logic [19:0] out_line;
    logic [31:0] out_calls;
    logic [31:0] out_user;
    logic [31:0] out_system;
    logic [31:0] out_real;
    logic [33:0] total_time;
    logic        last_entry;
  } out_item_t;

  typedef struct packed {
    logic [33:0] key;
    logic [15:0] func;
    logic [15:0] file;
    logic [19:0] line;
    logic [31:0] calls;
    logic [31:0] user;
    logic [31:0] sys;
    logic [31:0] rtime;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     ent;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/tkr_front.sv -----
`default_nettype none
module tkr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire tkr_pkg::in_item_t in_data,
  output logic                 push,
  output tkr_pkg::cmd_t        push_data,
  input  wire logic            q_full
);
  import tkr_pkg::*;

  logic  hold_valid_r, hold_valid_nxt;
  cmd_t  hold_r, hold_nxt;
  logic  accept;

  assign in_stall = hold_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push      = hold_valid_r && !q_full;
  assign push_data = hold_r;

  // Unused op codes are dropped here; the total is formed once on entry.
  always_comb begin
    hold_valid_nxt = push ? 1'b0 : hold_valid_r;
    hold_nxt       = hold_r;
    if (accept && in_data.op != OP_UNUSED) begin
      hold_valid_nxt      = 1'b1;
      hold_nxt.op         = in_data.op;
      hold_nxt.ent.key    = 34'(in_data.user_time) + 34'(in_data.system_time)
                          + 34'(in_data.real_time);
      hold_nxt.ent.func   = in_data.function_id;
      hold_nxt.ent.file   = in_data.file_id;
      hold_nxt.ent.line   = in_data.line_number;
      hold_nxt.ent.calls  = in_data.call_count;
      hold_nxt.ent.user   = in_data.user_time;
      hold_nxt.ent.sys    = in_data.system_time;
      hold_nxt.ent.rtime  = in_data.real_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/tkr_queue.sv -----
`default_nettype none
`include "assert_macros.svh"
module tkr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tkr_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output tkr_pkg::cmd_t      q_data
);
  import tkr_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cmd_t           mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = cnt_r == (PW+1)'(QUEUE_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TKR_ASSERT(a_q_cnt_cap, cnt_r <= (PW+1)'(QUEUE_DEPTH), "queue count beyond depth")
  `TKR_ASSERT_IMP(a_q_empty_ptrs, cnt_r == '0, wr_ptr_r == rd_ptr_r, "empty queue with pointer gap")

endmodule
`default_nettype wire

// ----- rtl/tkr_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module tkr_back #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [5:0]    list_limit,
  input  wire logic          q_valid,
  input  wire tkr_pkg::cmd_t q_data,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tkr_pkg::out_item_t out_data
);
  import tkr_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = ((CW > 6) ? CW : 6) + 1;

  back_state_t      state_r, state_nxt;
  entry_t           cells_r   [MAX_ENTRIES];
  entry_t           cell_nxt  [MAX_ENTRIES];
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [MAX_ENTRIES-1:0] ge, upto;
  logic [CMPW-1:0]  n_ext, lim_ext, max_ext, lim_eff, idx_ext;
  logic             ins_go, rot_go, append, grow, load, last;

  assign n_ext   = CMPW'(count_r);
  assign lim_ext = CMPW'(list_limit);
  assign max_ext = CMPW'(MAX_ENTRIES);
  assign lim_eff = (lim_ext > max_ext) ? max_ext : lim_ext;
  assign grow    = (n_ext + 1'b1) <= lim_eff;
  assign append  = !upto[MAX_ENTRIES-1] && (n_ext < max_ext);
  assign idx_ext = CMPW'(rd_idx_r);
  assign last    = (idx_ext + 1'b1) == n_ext;

  assign pop    = (state_r == BK_IDLE) && q_valid;
  assign ins_go = pop && q_data.op == OP_INSERT;
  assign load   = (state_r == BK_READ) && (!out_valid_r || !out_stall);
  assign rot_go = load;

  // Each cell compares against the new key and picks its own next value.
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic   prev_up;
    entry_t prev_cell, next_cell;

    assign ge[g]   = (CMPW'(g) < n_ext) && (q_data.ent.key >= cells_r[g].key);
    assign upto[g] = |ge[g:0];

    if (g == 0) begin : g_first
      assign prev_up   = 1'b0;
      assign prev_cell = cells_r[g];
    end else begin : g_rest
      assign prev_up   = upto[g-1];
      assign prev_cell = cells_r[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign next_cell = cells_r[g];
    end else begin : g_body
      assign next_cell = cells_r[g+1];
    end

    always_comb begin
      cell_nxt[g] = cells_r[g];
      if (ins_go) begin
        if ((upto[g] && !prev_up) || (append && CMPW'(g) == n_ext)) begin
          cell_nxt[g] = q_data.ent;
        end else if (prev_up && CMPW'(g) <= n_ext) begin
          cell_nxt[g] = prev_cell;
        end
      end else if (rot_go) begin
        if (CMPW'(g) == n_ext - 1'b1) begin
          cell_nxt[g] = cells_r[0];
        end else if (CMPW'(g) < n_ext - 1'b1) begin
          cell_nxt[g] = next_cell;
        end
      end
    end

    always_ff @(posedge clk) begin
      cells_r[g] <= cell_nxt[g];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop && q_data.op == OP_READ && count_r != '0) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        if (load && last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop) begin
      rd_idx_nxt = '0;
      case (q_data.op)
        OP_INSERT: count_nxt = grow ? count_r + 1'b1 : count_r;
        OP_CLEAR:  count_nxt = '0;
        default:   count_nxt = count_r;
      endcase
    end
    if (load) begin
      rd_idx_nxt                = rd_idx_r + 1'b1;
      out_valid_nxt             = 1'b1;
      out_data_nxt.rank         = idx_ext[4:0];
      out_data_nxt.out_function = cells_r[0].func;
      out_data_nxt.out_file     = cells_r[0].file;
      out_data_nxt.out_line     = cells_r[0].line;
      out_data_nxt.out_calls    = cells_r[0].calls;
      out_data_nxt.out_user     = cells_r[0].user;
      out_data_nxt.out_system   = cells_r[0].sys;
      out_data_nxt.out_real     = cells_r[0].rtime;
      out_data_nxt.total_time   = cells_r[0].key;
      out_data_nxt.last_entry   = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TKR_ASSERT(a_count_cap, count_r <= CW'(MAX_ENTRIES), "entry count beyond capacity")
  `TKR_ASSERT_IMP(a_no_pop_in_read, state_r == BK_READ, !pop, "command taken during read-out")
  `TKR_ASSERT_IMP(a_read_nonempty, state_r == BK_READ, count_r != '0, "read-out of an empty list")

endmodule
`default_nettype wire

// ----- rtl/top_k_cost_ranker_core.sv -----
// An accepted beat is registered in the front holding register, then in the queue, and
// reaches the list when the back end pops it. Read-out beats are registered and leave one
// beat per cycle while out_stall is low. The back end pops a command only while idle;
// a read-out rotates the list through its head cell, and a two-entry queue separates
// intake from the list.
// Reset: the list is empty, the limit is 20, no beat is pending; entry contents are not cleared.
`default_nettype none
module top_k_cost_ranker_core #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tkr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tkr_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [5:0]         cfg_data
);
  import tkr_pkg::*;

  logic [5:0] limit_r, limit_nxt;
  logic       push, q_full, pop, q_valid;
  cmd_t       push_data, q_data;

  assign cfg_ready = 1'b1;
  assign limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  tkr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  tkr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  tkr_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .list_limit (limit_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
